FILE: rtl/tssf_pkg.sv
package tssf_pkg;

	localparam int TEMP_W  = 16;
	localparam int SEG_W   = 7;
	localparam int DIGIT_W = 4;

	// Width of the scaled value that is split into decimal digits (max 9999).
	localparam int SPLIT_W = 14;
	localparam int PROD_W  = 30;

	// Reciprocal constants, exact for every dividend below 10000.
	localparam logic [15:0] DIV10_MUL   = 16'd6554;
	localparam int          DIV10_SH    = 16;
	localparam logic [15:0] DIV100_MUL  = 16'd5243;
	localparam int          DIV100_SH   = 19;
	localparam logic [15:0] DIV1000_MUL = 16'd16778;
	localparam int          DIV1000_SH  = 24;

	// Range limits of the shown value, in tenths.
	localparam logic [16:0] TENTHS_LIMIT_POS = 17'd1000;
	localparam logic [16:0] WHOLE_LIMIT_POS  = 17'd9995;
	localparam logic [16:0] TENTHS_LIMIT_NEG = 17'd100;
	localparam logic [16:0] WHOLE_LIMIT_NEG  = 17'd1000;
	localparam logic [16:0] ROUND_HALF       = 17'd5;

	localparam logic [SEG_W-1:0] SEG_MINUS = 7'b1000000;
	localparam logic [DIGIT_W-1:0] DIGIT_NINE = 4'd9;

	localparam logic [SEG_W-1:0] SEG_TABLE [10] = '{
		7'b0111111, 7'b0000110, 7'b1011011, 7'b1001111, 7'b1100110,
		7'b1101101, 7'b1111101, 7'b0000111, 7'b1111111, 7'b1101111
	};

	typedef enum logic [0:0] {
		REG_BAND_LOW  = 1'b0,
		REG_BAND_HIGH = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		COLOUR_GREEN = 2'd0,
		COLOUR_RED   = 2'd1,
		COLOUR_BLUE  = 2'd2
	} colour_t;

	typedef struct packed {
		logic [SEG_W-1:0] left;
		logic [SEG_W-1:0] middle;
		logic [SEG_W-1:0] right;
		logic             point;
	} disp_t;

	function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
		logic [SEG_W-1:0] s;
		s = '0;
		if (d <= DIGIT_NINE) begin
			s = SEG_TABLE[d];
		end
		return s;
	endfunction

endpackage

FILE: rtl/tssf_if.sv
interface tssf_in_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 func;
	logic signed [tssf_pkg::TEMP_W-1:0]   shown_value;
	logic signed [tssf_pkg::TEMP_W-1:0]   alarm_value;

	modport source(output valid, func, shown_value, alarm_value, input ready);
	modport sink(input valid, func, shown_value, alarm_value, output ready);
endinterface

interface tssf_out_if;
	logic                           valid;
	logic                           ready;
	logic [tssf_pkg::SEG_W-1:0]     left_segments;
	logic [tssf_pkg::SEG_W-1:0]     middle_segments;
	logic [tssf_pkg::SEG_W-1:0]     right_segments;
	logic                           point_on;
	logic [1:0]                     colour_class;
	logic                           unit_glyph;

	modport source(output valid, left_segments, middle_segments, right_segments,
		point_on, colour_class, unit_glyph, input ready);
	modport sink(input valid, left_segments, middle_segments, right_segments,
		point_on, colour_class, unit_glyph, output ready);
endinterface

interface tssf_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [0:0]                          index;
	logic signed [tssf_pkg::TEMP_W-1:0]  data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

FILE: rtl/tssf_fmt.sv
module tssf_fmt (
	input  logic signed [tssf_pkg::TEMP_W-1:0] shown,
	output tssf_pkg::disp_t                    disp
);
	import tssf_pkg::*;

	typedef enum logic [2:0] {
		RNG_POS_TENTHS,
		RNG_POS_WHOLE,
		RNG_POS_SAT,
		RNG_NEG_TENTHS,
		RNG_NEG_WHOLE,
		RNG_NEG_SAT
	} range_t;

	logic               neg;
	logic signed [16:0] sx;
	logic [16:0]        mag;
	range_t             rng;
	logic [SPLIT_W-1:0] y;
	logic [PROD_W-1:0]  p1, p2, p3;
	logic [9:0]         q1;
	logic [6:0]         q2;
	logic [3:0]         q3;
	logic [DIGIT_W-1:0] d0, d1, d2;

	assign neg = shown[TEMP_W-1];
	assign sx  = {shown[TEMP_W-1], shown};
	assign mag = neg ? 17'(-sx) : 17'(sx);

	always_comb begin
		priority if (!neg && mag < TENTHS_LIMIT_POS) begin
			rng = RNG_POS_TENTHS;
		end else if (!neg && mag < WHOLE_LIMIT_POS) begin
			rng = RNG_POS_WHOLE;
		end else if (!neg) begin
			rng = RNG_POS_SAT;
		end else if (mag < TENTHS_LIMIT_NEG) begin
			rng = RNG_NEG_TENTHS;
		end else if (mag < WHOLE_LIMIT_NEG) begin
			rng = RNG_NEG_WHOLE;
		end else begin
			rng = RNG_NEG_SAT;
		end
	end

	// Round half up before dropping the tenths of large positive values.
	assign y = (rng == RNG_POS_WHOLE) ? SPLIT_W'(mag + ROUND_HALF) : SPLIT_W'(mag);

	// Quotients by 10, 100 and 1000 in parallel from reciprocal products.
	assign p1 = PROD_W'(y) * PROD_W'(DIV10_MUL);
	assign p2 = PROD_W'(y) * PROD_W'(DIV100_MUL);
	assign p3 = PROD_W'(y) * PROD_W'(DIV1000_MUL);
	assign q1 = 10'(p1 >> DIV10_SH);
	assign q2 = 7'(p2 >> DIV100_SH);
	assign q3 = 4'(p3 >> DIV1000_SH);

	assign d0 = DIGIT_W'(y - SPLIT_W'(q1) * SPLIT_W'(10));
	assign d1 = DIGIT_W'(q1 - 10'(q2) * 10'd10);
	assign d2 = DIGIT_W'(q2 - 7'(q3) * 7'd10);

	always_comb begin
		unique case (rng)
			RNG_POS_TENTHS: begin
				disp = '{left: seg_of(d2), middle: seg_of(d1), right: seg_of(d0), point: 1'b1};
			end
			RNG_POS_WHOLE: begin
				disp = '{left: seg_of(q3), middle: seg_of(d2), right: seg_of(d1), point: 1'b0};
			end
			RNG_POS_SAT: begin
				disp = '{left: seg_of(DIGIT_NINE), middle: seg_of(DIGIT_NINE),
					right: seg_of(DIGIT_NINE), point: 1'b0};
			end
			RNG_NEG_TENTHS: begin
				disp = '{left: SEG_MINUS, middle: seg_of(d1), right: seg_of(d0), point: 1'b1};
			end
			RNG_NEG_WHOLE: begin
				disp = '{left: SEG_MINUS, middle: seg_of(d2), right: seg_of(d1), point: 1'b0};
			end
			RNG_NEG_SAT: begin
				disp = '{left: SEG_MINUS, middle: seg_of(DIGIT_NINE),
					right: seg_of(DIGIT_NINE), point: 1'b0};
			end
			default: begin
				disp = '0;
			end
		endcase
	end

endmodule

FILE: rtl/temperature_seven_segment_formatter.sv
// Temperature seven-segment formatter.
//
// reading: one beat per temperature sample: unit select, shown value and
// alarm value, both signed tenths of a degree.
// result:  one beat per reading: three segment patterns, decimal point,
// colour class (green in band, red above, blue below) and unit glyph.
// cfg:     band_low (index 0) and band_high (index 1), always ready; write
// only while no reading is in flight.
//
// A reading is captured in an input register and formatted in one pass of
// short logic (parallel reciprocal multiplies, digit table, band compare)
// into the result register, whose valid bit drives result valid. One reading
// is taken per cycle, sustained, while the receiver keeps result.ready high.
// When the receiver stalls, the result register holds its beat and the input
// register still takes one more reading; reading.ready drops only when both
// are full. Reset empties both registers and restores the band to 95.0..99.0.
module temperature_seven_segment_formatter (
	input  logic         clk,
	input  logic         arst_n,
	tssf_in_if.sink      reading,
	tssf_out_if.source   result,
	tssf_cfg_if.sink     cfg
);
	import tssf_pkg::*;

	logic                     valid_s1;
	logic                     func_s1;
	logic signed [TEMP_W-1:0] shown_s1;
	logic signed [TEMP_W-1:0] alarm_s1;

	logic                     valid_s2;
	disp_t                    disp_s2;
	colour_t                  colour_s2;
	logic                     glyph_s2;

	logic signed [TEMP_W-1:0] band_low_q;
	logic signed [TEMP_W-1:0] band_high_q;

	logic    adv_s2;
	logic    take_in;
	disp_t   disp;
	colour_t colour;

	assign adv_s2        = !valid_s2 || result.ready;
	assign reading.ready = !valid_s1 || adv_s2;
	assign take_in       = reading.valid && reading.ready;
	assign cfg.ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_low_q  <= TEMP_W'(950);
			band_high_q <= TEMP_W'(990);
		end else if (cfg.valid) begin
			unique case (cfg_idx_t'(cfg.index))
				REG_BAND_LOW:  band_low_q  <= cfg.data;
				REG_BAND_HIGH: band_high_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (reading.ready) begin
			valid_s1 <= reading.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			func_s1  <= reading.func;
			shown_s1 <= reading.shown_value;
			alarm_s1 <= reading.alarm_value;
		end
	end

	tssf_fmt u_fmt (
		.shown (shown_s1),
		.disp  (disp)
	);

	always_comb begin
		priority if (alarm_s1 >= band_low_q && alarm_s1 <= band_high_q) begin
			colour = COLOUR_GREEN;
		end else if (alarm_s1 > band_high_q) begin
			colour = COLOUR_RED;
		end else begin
			colour = COLOUR_BLUE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			disp_s2   <= disp;
			colour_s2 <= colour;
			glyph_s2  <= func_s1;
		end
	end

	assign result.valid           = valid_s2;
	assign result.left_segments   = disp_s2.left;
	assign result.middle_segments = disp_s2.middle;
	assign result.right_segments  = disp_s2.right;
	assign result.point_on        = disp_s2.point;
	assign result.colour_class    = colour_s2;
	assign result.unit_glyph      = glyph_s2;

	ap_fill_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s2) |=> valid_s2)
		else $error("input beat not moved into result register");

	ap_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s2) |=> (valid_s1 && $stable(shown_s1) && $stable(alarm_s1)))
		else $error("blocked input beat lost or changed");

	ap_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> reading.ready)
		else $error("empty input register refused a beat");

	ap_cfg_low: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg.valid && cfg.index == REG_BAND_LOW) |=> band_low_q == $past(cfg.data))
		else $error("band_low write not taken");

endmodule
